// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== rtl/lfk_pkg.sv =====
package lfk_pkg;

   localparam int CordicSteps = 24;
   localparam logic signed [27:0] PiQ24     = 28'sd52707179;
   localparam logic signed [27:0] HalfPiQ24 = 28'sd26353589;
   localparam logic signed [27:0] CordicKQ24 = 28'sd10188014;

   localparam logic [1:0] CSR_ABAD_LEN = 2'd0;
   localparam logic [1:0] CSR_HIP_LEN  = 2'd1;
   localparam logic [1:0] CSR_KNEE_LEN = 2'd2;
   localparam logic [1:0] CSR_KNEE_OFS = 2'd3;

   typedef struct packed {
      logic [13:0] abad_len;
      logic [13:0] hip_len;
      logic [13:0] knee_len;
      logic [13:0] knee_ofs;
   } cfg_type;

   function automatic logic signed [27:0] atan_q24(input logic [4:0] idx);
      logic signed [27:0] r;
      case (idx)
         5'd0: r = 28'sd13176795;
         5'd1: r = 28'sd7778716;
         5'd2: r = 28'sd4110060;
         5'd3: r = 28'sd2086331;
         5'd4: r = 28'sd1047214;
         5'd5: r = 28'sd524117;
         5'd6: r = 28'sd262123;
         5'd7: r = 28'sd131069;
         default: r = 28'sd1 <<< (5'd24 - idx);
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      logic signed [15:0] r;
      if (v > 64'sd32767) r = 16'sh7fff;
      else if (v < -64'sd32768) r = -16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

endpackage

// ===== rtl/lfk_cordic.sv =====
module lfk_cordic (
   input  logic               clock,
   input  logic               advance,
   input  logic signed [15:0] angle,
   output logic signed [16:0] sin_q15,
   output logic signed [16:0] cos_q15
);

   localparam int N = lfk_pkg::CordicSteps;

   logic signed [27:0] x_ff [0:N];
   logic signed [27:0] y_ff [0:N];
   logic signed [27:0] z_ff [0:N];
   logic               flip_ff [0:N];
   logic signed [27:0] z0_in;
   logic signed [27:0] zs;
   logic               flip_in;
   logic signed [18:0] cr;
   logic signed [18:0] sr;

   always_comb begin
      zs = 28'(angle) <<< 11;
      flip_in = 1'b0;
      z0_in = zs;
      if (zs > lfk_pkg::HalfPiQ24) begin
         z0_in = zs - lfk_pkg::PiQ24;
         flip_in = 1'b1;
      end else if (zs < -lfk_pkg::HalfPiQ24) begin
         z0_in = zs + lfk_pkg::PiQ24;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0] <= lfk_pkg::CordicKQ24;
         y_ff[0] <= '0;
         z_ff[0] <= z0_in;
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (advance) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][27]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - lfk_pkg::atan_q24(5'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + lfk_pkg::atan_q24(5'(i));
            end
         end
      end
   end

   assign cr = 19'((x_ff[N] + 28'sd256) >>> 9);
   assign sr = 19'((y_ff[N] + 28'sd256) >>> 9);
   assign cos_q15 = flip_ff[N] ? 17'(-cr) : 17'(cr);
   assign sin_q15 = flip_ff[N] ? 17'(-sr) : 17'(sr);

endmodule

// ===== rtl/lfk_kin.sv =====
module lfk_kin (
   input  logic               clock,
   input  logic               advance,
   input  lfk_pkg::cfg_type   cfg,
   input  logic               side,
   input  logic signed [16:0] s1, c1, s2, c2, s3, c3,
   input  logic signed [15:0] qd0, qd1, qd2,
   output logic signed [15:0] pos_x, pos_y, pos_z,
   output logic signed [15:0] vel_x, vel_y, vel_z
);

   // Stage A: angle products for the summed angles.
   logic signed [35:0] a_s2c3_ff, a_c2s3_ff, a_c2c3_ff, a_s2s3_ff;
   logic signed [16:0] a_s1_ff, a_c1_ff, a_s2_ff, a_c2_ff;
   logic signed [15:0] a_qd0_ff, a_qd1_ff, a_qd2_ff;
   logic signed [16:0] a_lat_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         a_s2c3_ff <= s2 * c3;
         a_c2s3_ff <= c2 * s3;
         a_c2c3_ff <= c2 * c3;
         a_s2s3_ff <= s2 * s3;
         a_s1_ff <= s1; a_c1_ff <= c1; a_s2_ff <= s2; a_c2_ff <= c2;
         a_qd0_ff <= qd0; a_qd1_ff <= qd1; a_qd2_ff <= qd2;
         a_lat_ff <= side ? 17'(cfg.abad_len) + 17'(cfg.knee_ofs)
                          : -(17'(cfg.abad_len) + 17'(cfg.knee_ofs));
      end
   end

   logic signed [36:0] s23w, c23w;
   assign s23w = (37'(a_s2c3_ff) + 37'(a_c2s3_ff) + 37'sd16384) >>> 15;
   assign c23w = (37'(a_c2c3_ff) - 37'(a_s2s3_ff) + 37'sd16384) >>> 15;

   // Stage B: link-length products.
   logic signed [33:0] b_l3s23_ff, b_l3c23_ff, b_l2s2_ff, b_l2c2_ff;
   logic signed [34:0] b_latc1_ff, b_lats1_ff;
   logic signed [16:0] b_s1_ff, b_c1_ff;
   logic signed [15:0] b_qd0_ff, b_qd1_ff, b_qd2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         b_l3s23_ff <= $signed({1'b0, cfg.knee_len}) * 19'(s23w);
         b_l3c23_ff <= $signed({1'b0, cfg.knee_len}) * 19'(c23w);
         b_l2s2_ff  <= $signed({1'b0, cfg.hip_len}) * a_s2_ff;
         b_l2c2_ff  <= $signed({1'b0, cfg.hip_len}) * a_c2_ff;
         b_latc1_ff <= a_lat_ff * a_c1_ff;
         b_lats1_ff <= a_lat_ff * a_s1_ff;
         b_s1_ff <= a_s1_ff; b_c1_ff <= a_c1_ff;
         b_qd0_ff <= a_qd0_ff; b_qd1_ff <= a_qd1_ff; b_qd2_ff <= a_qd2_ff;
      end
   end

   logic signed [34:0] sum_s, sum_c;
   assign sum_s = 35'(b_l3s23_ff) + 35'(b_l2s2_ff);
   assign sum_c = 35'(b_l3c23_ff) + 35'(b_l2c2_ff);

   // Stage C: second trig factor (Q30 terms, factor 2^15 applied later).
   logic signed [52:0] c_s1c_ff, c_c1c_ff, c_s1s_ff, c_c1s_ff, c_s1l3s_ff, c_c1l3s_ff;
   logic signed [34:0] c_sums_ff, c_sumc_ff, c_l3c23_ff, c_latc1_ff, c_lats1_ff;
   logic signed [15:0] c_qd0_ff, c_qd1_ff, c_qd2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         c_s1c_ff  <= 53'(sum_c * b_s1_ff);
         c_c1c_ff  <= 53'(sum_c * b_c1_ff);
         c_s1s_ff  <= 53'(sum_s * b_s1_ff);
         c_c1s_ff  <= 53'(sum_s * b_c1_ff);
         c_s1l3s_ff <= 53'(b_l3s23_ff * b_s1_ff);
         c_c1l3s_ff <= 53'(b_l3s23_ff * b_c1_ff);
         c_sums_ff <= sum_s; c_sumc_ff <= sum_c; c_l3c23_ff <= 35'(b_l3c23_ff);
         c_latc1_ff <= b_latc1_ff; c_lats1_ff <= b_lats1_ff;
         c_qd0_ff <= b_qd0_ff; c_qd1_ff <= b_qd1_ff; c_qd2_ff <= b_qd2_ff;
      end
   end

   logic signed [63:0] p0w, p1w, p2w;
   logic signed [63:0] j01w, j02w, j10w, j11w, j12w, j20w, j21w, j22w;
   localparam logic signed [63:0] R24 = 64'sd1 <<< 23;
   localparam logic signed [63:0] R30 = 64'sd1 <<< 29;
   always_comb begin
      p0w = 64'(c_sums_ff) <<< 15;
      p1w = (64'(c_latc1_ff) <<< 15) + 64'(c_s1c_ff);
      p2w = (64'(c_lats1_ff) <<< 15) - 64'(c_c1c_ff);
      j01w = ((64'(c_sumc_ff) <<< 15) + R24) >>> 24;
      j02w = ((64'(c_l3c23_ff) <<< 15) + R24) >>> 24;
      j10w = (64'(c_c1c_ff) - (64'(c_lats1_ff) <<< 15) + R24) >>> 24;
      j11w = (-64'(c_s1s_ff) + R24) >>> 24;
      j12w = (-64'(c_s1l3s_ff) + R24) >>> 24;
      j20w = (64'(c_s1c_ff) + (64'(c_latc1_ff) <<< 15) + R24) >>> 24;
      j21w = (64'(c_c1s_ff) + R24) >>> 24;
      j22w = (64'(c_c1l3s_ff) + R24) >>> 24;
   end

   // Stage D: Jacobian entries and saturated positions.
   logic signed [23:0] d_j01_ff, d_j02_ff, d_j10_ff, d_j11_ff, d_j12_ff;
   logic signed [23:0] d_j20_ff, d_j21_ff, d_j22_ff;
   logic signed [15:0] d_px_ff, d_py_ff, d_pz_ff;
   logic signed [15:0] d_qd0_ff, d_qd1_ff, d_qd2_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         d_j01_ff <= 24'(j01w); d_j02_ff <= 24'(j02w);
         d_j10_ff <= 24'(j10w); d_j11_ff <= 24'(j11w); d_j12_ff <= 24'(j12w);
         d_j20_ff <= 24'(j20w); d_j21_ff <= 24'(j21w); d_j22_ff <= 24'(j22w);
         d_px_ff <= lfk_pkg::sat16((p0w + R30) >>> 30);
         d_py_ff <= lfk_pkg::sat16((p1w + R30) >>> 30);
         d_pz_ff <= lfk_pkg::sat16((p2w + R30) >>> 30);
         d_qd0_ff <= c_qd0_ff; d_qd1_ff <= c_qd1_ff; d_qd2_ff <= c_qd2_ff;
      end
   end

   // Stage E: rate products.
   logic signed [39:0] e_m01_ff, e_m02_ff, e_m10_ff, e_m11_ff, e_m12_ff;
   logic signed [39:0] e_m20_ff, e_m21_ff, e_m22_ff;
   logic signed [15:0] e_px_ff, e_py_ff, e_pz_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         e_m01_ff <= d_j01_ff * d_qd1_ff; e_m02_ff <= d_j02_ff * d_qd2_ff;
         e_m10_ff <= d_j10_ff * d_qd0_ff; e_m11_ff <= d_j11_ff * d_qd1_ff;
         e_m12_ff <= d_j12_ff * d_qd2_ff; e_m20_ff <= d_j20_ff * d_qd0_ff;
         e_m21_ff <= d_j21_ff * d_qd1_ff; e_m22_ff <= d_j22_ff * d_qd2_ff;
         e_px_ff <= d_px_ff; e_py_ff <= d_py_ff; e_pz_ff <= d_pz_ff;
      end
   end

   localparam logic signed [63:0] R17 = 64'sd1 <<< 16;
   assign pos_x = e_px_ff;
   assign pos_y = e_py_ff;
   assign pos_z = e_pz_ff;
   assign vel_x = lfk_pkg::sat16((64'(e_m01_ff) + 64'(e_m02_ff) + R17) >>> 17);
   assign vel_y = lfk_pkg::sat16((64'(e_m10_ff) + 64'(e_m11_ff) + 64'(e_m12_ff)
                                  + R17) >>> 17);
   assign vel_z = lfk_pkg::sat16((64'(e_m20_ff) + 64'(e_m21_ff) + 64'(e_m22_ff)
                                  + R17) >>> 17);

endmodule

// ===== rtl/leg_forward_kinematics.sv =====
// Foot position and velocity of a three-joint leg.
// Request channel (req_valid/req_stall): three Q2.13 joint angles, three
// joint rates (x256) and a side bit. Response channel (rsp_valid/rsp_stall):
// saturated foot position (x16384) and velocity (x2048), one beat per request.
// A beat is accepted when valid is high and stall is low.
// Throughput is one beat per cycle while the response channel is not stalled.
// A beat passes one input stage, 24 CORDIC stages, five multiply stages of
// the kinematics and one output register, all advancing together.
// The pipeline holds only while the output register is full and stalled and
// the last pipeline stage holds a beat; req_stall is raised exactly then.
// The user must write link lengths on the csr_ port only while no beat is in
// flight; the block itself does not enforce this.
// Synchronous reset clears all valid bits and restores the default lengths.
`include "assert_macros.svh"

module leg_forward_kinematics (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_angle_abad,
   input  logic signed [15:0] req_angle_hip,
   input  logic signed [15:0] req_angle_knee,
   input  logic signed [15:0] req_rate_abad,
   input  logic signed [15:0] req_rate_hip,
   input  logic signed [15:0] req_rate_knee,
   input  logic               req_side_positive,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_foot_pos_x,
   output logic signed [15:0] rsp_foot_pos_y,
   output logic signed [15:0] rsp_foot_pos_z,
   output logic signed [15:0] rsp_foot_vel_x,
   output logic signed [15:0] rsp_foot_vel_y,
   output logic signed [15:0] rsp_foot_vel_z,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [13:0]        csr_data
);

   localparam int Cd = lfk_pkg::CordicSteps + 1;
   localparam int Depth = Cd + 5;

   lfk_pkg::cfg_type cfg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.abad_len <= 14'd1016;
         cfg_ff.hip_len  <= 14'd3424;
         cfg_ff.knee_len <= 14'd3195;
         cfg_ff.knee_ofs <= 14'd66;
      end else if (csr_write) begin
         unique case (csr_index)
            lfk_pkg::CSR_ABAD_LEN: cfg_ff.abad_len <= csr_data;
            lfk_pkg::CSR_HIP_LEN:  cfg_ff.hip_len  <= csr_data;
            lfk_pkg::CSR_KNEE_LEN: cfg_ff.knee_len <= csr_data;
            lfk_pkg::CSR_KNEE_OFS: cfg_ff.knee_ofs <= csr_data;
            default: ;
         endcase
      end
   end

   logic [Depth-1:0] vld_ff;
   logic             advance;
   logic             out_vld_ff;

   // The pipeline moves unless its last stage holds a beat and the output
   // register is full and stalled.
   assign advance = !(out_vld_ff && rsp_stall && vld_ff[Depth-1]);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[Depth-2:0], req_valid};
   end

   // Side and rates ride alongside the CORDIC stages.
   logic [Cd-1:0]      side_ff;
   logic signed [15:0] qd0_ff [0:Cd-1];
   logic signed [15:0] qd1_ff [0:Cd-1];
   logic signed [15:0] qd2_ff [0:Cd-1];
   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff <= {side_ff[Cd-2:0], req_side_positive};
         qd0_ff[0] <= req_rate_abad;
         qd1_ff[0] <= req_rate_hip;
         qd2_ff[0] <= req_rate_knee;
         for (int k = 1; k < Cd; k++) begin
            qd0_ff[k] <= qd0_ff[k-1];
            qd1_ff[k] <= qd1_ff[k-1];
            qd2_ff[k] <= qd2_ff[k-1];
         end
      end
   end

   logic signed [16:0] s1, c1, s2, c2, s3, c3;
   lfk_cordic u_cordic_abad (.clock, .advance, .angle(req_angle_abad),
                             .sin_q15(s1), .cos_q15(c1));
   lfk_cordic u_cordic_hip  (.clock, .advance, .angle(req_angle_hip),
                             .sin_q15(s2), .cos_q15(c2));
   lfk_cordic u_cordic_knee (.clock, .advance, .angle(req_angle_knee),
                             .sin_q15(s3), .cos_q15(c3));

   logic signed [15:0] px, py, pz, vx, vy, vz;
   lfk_kin u_kin (
      .clock, .advance, .cfg(cfg_ff), .side(side_ff[Cd-1]),
      .s1, .c1, .s2, .c2, .s3, .c3,
      .qd0(qd0_ff[Cd-1]), .qd1(qd1_ff[Cd-1]), .qd2(qd2_ff[Cd-1]),
      .pos_x(px), .pos_y(py), .pos_z(pz), .vel_x(vx), .vel_y(vy), .vel_z(vz)
   );

   logic load_out;
   assign load_out = advance && vld_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (load_out) out_vld_ff <= 1'b1;
      else if (!rsp_stall) out_vld_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_foot_pos_x <= px; rsp_foot_pos_y <= py; rsp_foot_pos_z <= pz;
         rsp_foot_vel_x <= vx; rsp_foot_vel_y <= vy; rsp_foot_vel_z <= vz;
      end
   end

   assign rsp_valid = out_vld_ff;

   `ASSERT_IMPLY(a_hold_when_full, clock, reset, out_vld_ff && rsp_stall && vld_ff[Depth-1], req_stall, "pipeline advanced over a stalled beat")
   `ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, vld_ff[0], "accepted beat lost at pipeline head")
   `ASSERT_NEXT(a_out_loaded, clock, reset, load_out, rsp_valid, "finished beat not presented")

endmodule

// ===== tb/sv/leg_forward_kinematics_test.sv =====
`timescale 1ns / 100ps

module leg_forward_kinematics_test;

   typedef struct {
      logic signed [15:0] pos_x, pos_y, pos_z;
      logic signed [15:0] vel_x, vel_y, vel_z;
   } foot_state_type;

   class scoreboard_type;
      longint abad_len, hip_len, knee_len, knee_ofs;
      foot_state_type pending[$];
      int mismatches;
      int beats_in;
      int beats_out;

      function new();
         abad_len = 1016;
         hip_len = 3424;
         knee_len = 3195;
         knee_ofs = 66;
      endfunction

      function void set_length(logic [1:0] idx, logic [13:0] val);
         case (idx)
            lfk_pkg::CSR_ABAD_LEN: abad_len = val;
            lfk_pkg::CSR_HIP_LEN: hip_len = val;
            lfk_pkg::CSR_KNEE_LEN: knee_len = val;
            lfk_pkg::CSR_KNEE_OFS: knee_ofs = val;
            default: ;
         endcase
      endfunction

      function longint rnd(longint v, int s);
         return (v + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      function logic signed [15:0] clamp16(longint v);
         if (v > 32767) return 16'sh7fff;
         if (v < -32768) return -16'sh8000;
         return v[15:0];
      endfunction

      function void sin_cos(longint ang, output longint sn, output longint cs);
         longint atan_tab[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
            262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2};
         longint z, x, y, nx;
         bit flip;
         z = ang * 2048;
         x = lfk_pkg::CordicKQ24;
         y = 0;
         flip = 0;
         if (z > lfk_pkg::HalfPiQ24) begin
            z -= lfk_pkg::PiQ24;
            flip = 1;
         end else if (z < -longint'(lfk_pkg::HalfPiQ24)) begin
            z += lfk_pkg::PiQ24;
            flip = 1;
         end
         for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               z -= atan_tab[i];
            end else begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               z += atan_tab[i];
            end
            x = nx;
         end
         cs = rnd(x, 9);
         sn = rnd(y, 9);
         if (flip) begin
            cs = -cs;
            sn = -sn;
         end
      endfunction

      function void note_request(logic signed [15:0] a0, a1, a2, r0, r1, r2, logic side);
         longint s1, c1, s2, c2, s3, c3, s23, c23, lat, l2, l3;
         longint j01, j02, j10, j11, j12, j20, j21, j22;
         foot_state_type e;
         l2 = hip_len;
         l3 = knee_len;
         lat = (abad_len + knee_ofs) * (side ? 1 : -1);
         sin_cos(a0, s1, c1);
         sin_cos(a1, s2, c2);
         sin_cos(a2, s3, c3);
         s23 = rnd(s2 * c3 + c2 * s3, 15);
         c23 = rnd(c2 * c3 - s2 * s3, 15);
         j01 = rnd((l3 * c23 + l2 * c2) * 32768, 24);
         j02 = rnd(l3 * c23 * 32768, 24);
         j10 = rnd(l3 * c1 * c23 + l2 * c1 * c2 - lat * s1 * 32768, 24);
         j11 = rnd(-(l3 * s1 * s23) - l2 * s1 * s2, 24);
         j12 = rnd(-(l3 * s1 * s23), 24);
         j20 = rnd(l3 * s1 * c23 + l2 * c2 * s1 + lat * c1 * 32768, 24);
         j21 = rnd(l3 * c1 * s23 + l2 * c1 * s2, 24);
         j22 = rnd(l3 * c1 * s23, 24);
         e.pos_x = clamp16(rnd((l3 * s23 + l2 * s2) * 32768, 30));
         e.pos_y = clamp16(rnd(lat * c1 * 32768 + l3 * s1 * c23 + l2 * c2 * s1, 30));
         e.pos_z = clamp16(rnd(lat * s1 * 32768 - l3 * c1 * c23 - l2 * c1 * c2, 30));
         e.vel_x = clamp16(rnd(j01 * r1 + j02 * r2, 17));
         e.vel_y = clamp16(rnd(j10 * r0 + j11 * r1 + j12 * r2, 17));
         e.vel_z = clamp16(rnd(j20 * r0 + j21 * r1 + j22 * r2, 17));
         pending.push_back(e);
         beats_in++;
      endfunction

      task report(string what, int got, int want);
         $display("mismatch at %0t: beat %0d %s got %0d expected %0d",
                  $time, beats_out, what, got, want);
         mismatches++;
      endtask

      task check_response(foot_state_type got);
         foot_state_type e;
         if (pending.size() == 0) begin
            report("unexpected beat", 1, 0);
         end else begin
            e = pending.pop_front();
            if (got.pos_x !== e.pos_x) report("pos_x", got.pos_x, e.pos_x);
            if (got.pos_y !== e.pos_y) report("pos_y", got.pos_y, e.pos_y);
            if (got.pos_z !== e.pos_z) report("pos_z", got.pos_z, e.pos_z);
            if (got.vel_x !== e.vel_x) report("vel_x", got.vel_x, e.vel_x);
            if (got.vel_y !== e.vel_y) report("vel_y", got.vel_y, e.vel_y);
            if (got.vel_z !== e.vel_z) report("vel_z", got.vel_z, e.vel_z);
         end
         beats_out++;
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [15:0] req_angle_abad = 0, req_angle_hip = 0, req_angle_knee = 0;
   logic signed [15:0] req_rate_abad = 0, req_rate_hip = 0, req_rate_knee = 0;
   logic req_side_positive = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [15:0] rsp_foot_pos_x, rsp_foot_pos_y, rsp_foot_pos_z;
   logic signed [15:0] rsp_foot_vel_x, rsp_foot_vel_y, rsp_foot_vel_z;
   logic csr_write = 0;
   logic [1:0] csr_index = 0;
   logic [13:0] csr_data = 0;

   scoreboard_type board = new();
   bit quiet = 0;
   int settings_used = 0;

   leg_forward_kinematics u_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      foot_state_type got;
      if (!reset && req_valid && !req_stall)
         board.note_request(req_angle_abad, req_angle_hip, req_angle_knee, req_rate_abad,
                            req_rate_hip, req_rate_knee, req_side_positive);
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_foot_pos_x, rsp_foot_pos_y, rsp_foot_pos_z,
                 rsp_foot_vel_x, rsp_foot_vel_y, rsp_foot_vel_z};
         board.check_response(got);
      end
   end

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall = 1;
            repeat ($urandom_range(1, 11)) @(negedge clock);
            rsp_stall = 0;
         end
         @(negedge clock);
      end
   end

   task send_beat(logic signed [15:0] a0, a1, a2, r0, r1, r2, logic side);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_angle_abad = a0;
      req_angle_hip = a1;
      req_angle_knee = a2;
      req_rate_abad = r0;
      req_rate_hip = r1;
      req_rate_knee = r2;
      req_side_positive = side;
      req_valid = 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task send_random(int count);
      logic signed [15:0] a[3], r[3];
      for (int n = 0; n < count; n++) begin
         for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 2) == 0) begin
               a[k] = 16'($urandom);
               r[k] = 16'($urandom);
            end else begin
               a[k] = $signed(16'($urandom_range(0, 25736))) - 16'sd12868;
               r[k] = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
            end
         end
         send_beat(a[0], a[1], a[2], r[0], r[1], r[2], 1'($urandom_range(0, 1)));
      end
      req_valid = 0;
   endtask

   task drain;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task set_lengths(logic [13:0] l0, l1, l2, l3);
      logic [13:0] v[4];
      v = '{l0, l1, l2, l3};
      for (int k = 0; k < 4; k++) begin
         csr_write = 1;
         csr_index = 2'(k);
         csr_data = v[k];
         @(negedge clock);
         board.set_length(2'(k), v[k]);
      end
      csr_write = 0;
      settings_used++;
   endtask

   initial begin
      logic signed [15:0] edges[8];
      edges = '{16'sh7fff, -16'sh8000, 16'sd0, 16'sd12867, 16'sd12868,
                -16'sd12868, -16'sd12869, 16'sd25736};
      repeat (8) @(negedge clock);
      reset = 0;
      @(negedge clock);
      for (int k = 0; k < 8; k++)
         send_beat(edges[k], edges[7 - k], edges[(k + 3) % 8], 16'sh7fff, -16'sh8000,
                   16'sh7fff, k[0]);
      send_beat(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
      send_beat(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000,
                1'b1);
      send_beat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
      send_random(150);
      drain();
      set_lengths(14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff);
      send_beat(16'sd0, 16'sd0, 16'sd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
      send_beat(16'sd6434, 16'sd12867, -16'sd12868, -16'sh8000, 16'sh7fff, -16'sh8000,
                1'b0);
      send_random(150);
      drain();
      set_lengths(14'd0, 14'd0, 14'd0, 14'd0);
      send_random(120);
      drain();
      set_lengths(14'($urandom), 14'($urandom), 14'($urandom), 14'($urandom));
      send_random(150);
      drain();
      set_lengths(14'h3fff, 14'd0, 14'h3fff, 14'd0);
      send_random(100);
      drain();
      set_lengths(14'd1016, 14'd3424, 14'd3195, 14'd66);
      quiet = 1;
      send_random(130);
      drain();
      $display("covered %0d request beats and %0d response beats over %0d length settings",
               board.beats_in, board.beats_out, settings_used + 1);
      $display("including angle fold boundaries, extreme rates and saturated outputs");
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("[leg_forward_kinematics] OK");
      end else begin
         $display("[leg_forward_kinematics] ERROR");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("[leg_forward_kinematics] ERROR");
      $finish;
   end

endmodule
